// File: rtl/core/palette_match_2bpp_packer_core_macros.svh
// Assertion macros for the palette match 2bpp packer core.
// Clocked on clk_i, disabled while rst_ni is low.
`ifndef PALETTE_MATCH_2BPP_PACKER_CORE_MACROS_SVH
`define PALETTE_MATCH_2BPP_PACKER_CORE_MACROS_SVH

// same-cycle implication
`define PM2_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PM2_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/pm2bpp_pkg.sv
// Shared types and constants for the palette match 2bpp packer.
// No dependencies.
package pm2bpp_pkg;

  localparam int COLOR_W     = 15;
  localparam int NUM_COLORS  = 4;
  localparam int ROW_PIXELS  = 8;
  localparam int CFG_REGS    = 3;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = COLOR_W * NUM_COLORS;
  localparam int ADDR_W      = 10;
  localparam int TILE_BYTES  = 16;

  typedef logic [COLOR_W-1:0] color_t;
  // colour k sits at bits 15k+14 .. 15k
  typedef logic [NUM_COLORS-1:0][COLOR_W-1:0] palette_t;

  typedef enum logic [1:0] {
    STATUS_OK          = 2'd0,
    STATUS_BAD_PALETTE = 2'd1,
    STATUS_MISS        = 2'd2
  } status_e;

  typedef struct packed {
    color_t     pixel_0;
    color_t     pixel_1;
    color_t     pixel_2;
    color_t     pixel_3;
    color_t     pixel_4;
    color_t     pixel_5;
    color_t     pixel_6;
    color_t     pixel_7;
    logic [1:0] palette_select;
    logic [2:0] tile_column;
    logic [2:0] tile_row;
    logic [2:0] pixel_row;
  } in_word_t;

  typedef struct packed {
    logic [7:0]        plane_low;
    logic [7:0]        plane_high;
    logic [ADDR_W-1:0] byte_address;
    status_e           status;
    logic [2:0]        miss_column;
  } result_t;

  // outcome of matching one row against a palette
  typedef struct packed {
    logic [7:0] plane_low;
    logic [7:0] plane_high;
    status_e    status;
    logic [2:0] miss_column;
  } match_res_t;

endpackage

// File: rtl/core/pm2bpp_pal_regs.sv
// Palette colour registers with write port and palette select mux.
// Depends on pm2bpp_pkg.
module pm2bpp_pal_regs import pm2bpp_pkg::*; #(
  parameter int NUM_PALETTES = 3
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic [1:0]            palette_select_i,
  output palette_t              palette_o,
  output logic                  palette_ok_o
);

  palette_t pal_q [NUM_PALETTES];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int p = 0; p < NUM_PALETTES; p++) begin
        pal_q[p] <= '0;
      end
    end else if (cfg_we_i) begin
      // writes to palettes not built are dropped
      for (int p = 0; p < NUM_PALETTES; p++) begin
        if (cfg_index_i == CFG_IDX_W'(p)) begin
          pal_q[p] <= cfg_wdata_i;
        end
      end
    end
  end

  always_comb begin
    palette_o    = '0;
    palette_ok_o = 1'b0;
    for (int p = 0; p < NUM_PALETTES; p++) begin
      if (palette_select_i == 2'(p)) begin
        palette_o    = pal_q[p];
        palette_ok_o = 1'b1;
      end
    end
  end

endmodule

// File: rtl/core/pm2bpp_row_match.sv
// Matches eight pixels against one palette and packs the two bitplanes.
// Depends on pm2bpp_pkg.
module pm2bpp_row_match import pm2bpp_pkg::*; (
  input  in_word_t   item_i,
  input  palette_t   palette_i,
  input  logic       palette_ok_i,
  output match_res_t match_o
);

  color_t                           px [ROW_PIXELS];
  logic [ROW_PIXELS-1:0]            found;
  logic [ROW_PIXELS-1:0][1:0]       idx;
  logic [NUM_COLORS-1:0]            hit;
  logic [2:0]                       first_miss;
  logic [7:0]                       low;
  logic [7:0]                       high;

  assign px[0] = item_i.pixel_0;
  assign px[1] = item_i.pixel_1;
  assign px[2] = item_i.pixel_2;
  assign px[3] = item_i.pixel_3;
  assign px[4] = item_i.pixel_4;
  assign px[5] = item_i.pixel_5;
  assign px[6] = item_i.pixel_6;
  assign px[7] = item_i.pixel_7;

  always_comb begin
    found = '0;
    idx   = '0;
    hit   = '0;
    for (int x = 0; x < ROW_PIXELS; x++) begin
      for (int k = 0; k < NUM_COLORS; k++) begin
        hit[k] = (palette_i[k] == px[x]);
      end
      found[x] = |hit;
      // lowest index wins on duplicate colours
      if (hit[0])      idx[x] = 2'd0;
      else if (hit[1]) idx[x] = 2'd1;
      else if (hit[2]) idx[x] = 2'd2;
      else             idx[x] = 2'd3;
    end
  end

  always_comb begin
    first_miss = '0;
    for (int x = ROW_PIXELS - 1; x >= 0; x--) begin
      if (!found[x]) begin
        first_miss = 3'(x);
      end
    end
  end

  always_comb begin
    for (int x = 0; x < ROW_PIXELS; x++) begin
      low[ROW_PIXELS-1-x]  = idx[x][0];
      high[ROW_PIXELS-1-x] = idx[x][1];
    end
  end

  always_comb begin
    match_o = '{plane_low: '0, plane_high: '0, status: STATUS_OK, miss_column: '0};
    if (!palette_ok_i) begin
      match_o.status = STATUS_BAD_PALETTE;
    end else if (!(&found)) begin
      match_o.status      = STATUS_MISS;
      match_o.miss_column = first_miss;
    end else begin
      match_o.plane_low  = low;
      match_o.plane_high = high;
    end
  end

endmodule

// File: rtl/core/palette_match_2bpp_packer_core.sv
// Top level of the palette match 2bpp packer: input register, row matcher, result register.
// Depends on pm2bpp_pkg, pm2bpp_pal_regs, pm2bpp_row_match and the macros header.
//
// Usage:
//   Input: drive in_word_i and raise start; the word is taken at any rising edge with
//   start high and busy low. busy stays low, so a word may be given every cycle.
//   Output: result_o is valid for exactly one cycle while result_valid_o is high.
//   The word passes the input register, then the result register; the strobe rises
//   as the result register loads, and the result is captured while the strobe is high.
//   Throughput is one row word per cycle; the path between the two registers is
//   the 32 colour compares, a priority pick and the address multiply-add.
//   Configuration: cfg_we_i writes cfg_wdata_i into palette register cfg_index_i;
//   indices at or above NUM_PALETTES are ignored. Write only while idle.
//   Reset: rst_ni low clears the palettes to zero and drops all words in flight.
//   The receiver has no back-pressure: each result must be captured when strobed.
module palette_match_2bpp_packer_core import pm2bpp_pkg::*; #(
  parameter int NUM_PALETTES = 3,
  parameter int TILE_ROWS    = 6
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  output logic                  busy,
  input  in_word_t              in_word_i,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  output logic                  result_valid_o,
  output result_t               result_o
);

  `include "palette_match_2bpp_packer_core_macros.svh"

  logic       in_valid_q, in_valid_d;
  in_word_t   in_word_q;
  logic       res_valid_q;
  result_t    res_q, res_d;
  palette_t   palette;
  logic       palette_ok;
  match_res_t match;
  logic [ADDR_W-1:0] tile_idx;

  assign busy       = 1'b0;
  assign in_valid_d = start && !busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_d) begin
      in_word_q <= in_word_i;
    end
  end

  pm2bpp_pal_regs #(
    .NUM_PALETTES (NUM_PALETTES)
  ) u_pal_regs (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .palette_select_i (in_word_q.palette_select),
    .palette_o        (palette),
    .palette_ok_o     (palette_ok)
  );

  pm2bpp_row_match u_row_match (
    .item_i       (in_word_q),
    .palette_i    (palette),
    .palette_ok_i (palette_ok),
    .match_o      (match)
  );

  // tiles column-major; out-of-range rows are not checked and alias into the next column
  assign tile_idx = ADDR_W'(ADDR_W'(in_word_q.tile_column) * ADDR_W'(TILE_ROWS))
                  + ADDR_W'(in_word_q.tile_row);

  always_comb begin
    res_d.plane_low    = match.plane_low;
    res_d.plane_high   = match.plane_high;
    res_d.byte_address = ADDR_W'(tile_idx * ADDR_W'(TILE_BYTES))
                       + ADDR_W'({in_word_q.pixel_row, 1'b0});
    res_d.status       = match.status;
    res_d.miss_column  = match.miss_column;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_q) begin
      res_q <= res_d;
    end
  end

  assign result_valid_o = res_valid_q;
  assign result_o       = res_q;

  `PM2_ASSERT_NEXT(a_word_reaches_result, in_valid_q, result_valid_o, "word lost in result stage")
  `PM2_ASSERT_NEXT(a_start_loads_input, start && !busy, in_valid_q, "accepted word not registered")
  `PM2_ASSERT_NOW(a_fail_clears_planes, result_valid_o && result_o.status != STATUS_OK,
                  result_o.plane_low == 8'd0 && result_o.plane_high == 8'd0,
                  "planes not cleared on failed row")
  `PM2_ASSERT_NOW(a_miss_col_only_on_miss, result_valid_o && result_o.status != STATUS_MISS,
                  result_o.miss_column == 3'd0, "miss column set without a miss")

endmodule
